// File: sv/otp_pkg.sv
// Shared types, codes and helpers of the one-shot timer pool.
package otp_pkg;

  localparam int TIME_W      = 48;
  localparam int DUR_W       = 32;
  localparam int TAG_W       = 16;
  localparam int INC_W       = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [INC_W-1:0] TICK_INC_RESET = 32'd54688;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_INSERT   = 2'd1,
    OP_DELETE   = 2'd2,
    OP_FREE_ALL = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_INS_OK   = 2'd0,
    KIND_INS_FAIL = 2'd1,
    KIND_EXPIRED  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_EMIT
  } bk_state_t;

  // Classified request as held in the queue
  typedef struct packed {
    op_t              op;
    logic [DUR_W-1:0] duration;
    logic [TAG_W-1:0] tag;
    logic [1:0]       sel;
  } work_t;

  // Head of the queue as seen by the back end
  typedef struct packed {
    logic  valid;
    work_t item;
  } q_head_t;

  // Add with saturation at the largest time value
  function automatic logic [TIME_W-1:0] sat_add(logic [TIME_W-1:0] a,
                                                 logic [DUR_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {{(TIME_W - DUR_W + 1){1'b0}}, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

// File: sv/otp_if.sv
// Channel interfaces of the timer pool: requests, results, configuration.
interface otp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] duration;
  logic [15:0] timer_tag;
  logic [1:0]  slot_select;

  modport source (output valid, opcode, duration, timer_tag, slot_select, input ready);
  modport sink   (input valid, opcode, duration, timer_tag, slot_select, output ready);
endinterface

interface otp_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  slot_number;
  logic [15:0] expired_tag;
  logic [47:0] time_now;
  logic        last;

  modport source (output valid, kind, slot_number, expired_tag, time_now, last,
                  input ready);
  modport sink   (input valid, kind, slot_number, expired_tag, time_now, last,
                  output ready);
endinterface

interface otp_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: sv/otp_front.sv
// Front end: accepts requests, decodes the opcode and queues them.
module otp_front
  import otp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  otp_req_if.sink req,
  output q_head_t head,
  input  logic    pop
);

  work_t              q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  work_t              in_item;
  logic               push;
  logic               do_pop;

  // Classify the incoming request
  always_comb begin
    case (req.opcode)
      OP_TICK:   in_item.op = OP_TICK;
      OP_INSERT: in_item.op = OP_INSERT;
      OP_DELETE: in_item.op = OP_DELETE;
      default:   in_item.op = OP_FREE_ALL;
    endcase
    in_item.duration = req.duration;
    in_item.tag      = req.timer_tag;
    in_item.sel      = req.slot_select;
  end

  assign req.ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign push      = req.valid && req.ready;
  assign do_pop    = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.item  = q[rd_ptr];

  // Store the request at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: sv/otp_back.sv
// Back end: slot state, time counter, expiry scan and result register.
module otp_back
  import otp_pkg::*;
#(
  parameter int SLOT_COUNT = 3
) (
  input  logic      clk,
  input  logic      rst,
  input  q_head_t   head,
  output logic      pop,
  otp_cfg_if.sink   cfg,
  otp_rsp_if.source rsp
);

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  bk_state_t             state, state_next;
  logic [INC_W-1:0]      tick_inc;
  logic [TIME_W-1:0]     cur_time, cur_time_next;
  logic [SLOT_COUNT-1:0] busy, busy_next;
  logic [SLOT_COUNT-1:0] pending, pending_next;
  logic [TIME_W-1:0]     expiry [SLOT_COUNT];
  logic [TAG_W-1:0]      slot_tag [SLOT_COUNT];

  logic [SLOT_COUNT-1:0] due;
  logic                  free_found;
  logic [SLOT_W-1:0]     free_idx;
  logic [SLOT_W-1:0]     pick_idx;
  logic [SLOT_COUNT-1:0] pick_hot;
  logic [TAG_W-1:0]      pick_tag;
  logic                  found;
  logic                  ins_we;
  logic [TIME_W-1:0]     ins_expiry;

  logic                  out_valid, out_valid_next;
  logic                  out_load;
  kind_t                 out_kind;
  logic [SLOT_W-1:0]     out_idx;
  logic [TAG_W-1:0]      out_tag;
  logic                  out_last;
  logic                  out_free;

  kind_t                 r_kind;
  logic [SLOT_W+1:0]     r_idx_ext;
  logic [TAG_W-1:0]      r_tag;
  logic                  r_last;

  assign cfg.ready = 1'b1;

  // Compare every busy slot against the counter
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      due[i] = busy[i] && (cur_time >= expiry[i]);
    end
  end

  // Lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!free_found && !busy[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  // Lowest-numbered pending slot and its tag
  always_comb begin
    found    = 1'b0;
    pick_idx = '0;
    pick_hot = '0;
    pick_tag = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!found && pending[i]) begin
        found       = 1'b1;
        pick_idx    = SLOT_W'(i);
        pick_hot[i] = 1'b1;
        pick_tag    = slot_tag[i];
      end
    end
  end

  assign ins_expiry = sat_add(cur_time, head.item.duration);
  assign out_free   = !out_valid || rsp.ready;

  // Sequence requests and build results
  always_comb begin
    state_next     = state;
    cur_time_next  = cur_time;
    busy_next      = busy;
    pending_next   = pending;
    pop            = 1'b0;
    ins_we         = 1'b0;
    out_load       = 1'b0;
    out_kind       = KIND_INS_OK;
    out_idx        = '0;
    out_tag        = '0;
    out_last       = 1'b1;
    out_valid_next = out_valid && !rsp.ready;

    case (state)
      BK_IDLE: begin
        if (head.valid) begin
          case (head.item.op)
            OP_TICK: begin
              pop           = 1'b1;
              cur_time_next = sat_add(cur_time, tick_inc);
              state_next    = BK_SCAN;
            end
            OP_INSERT: begin
              if (out_free) begin
                pop      = 1'b1;
                out_load = 1'b1;
                if (free_found) begin
                  ins_we   = 1'b1;
                  out_kind = KIND_INS_OK;
                  out_idx  = free_idx;
                  for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (free_idx == SLOT_W'(i)) begin
                      busy_next[i] = 1'b1;
                    end
                  end
                end else begin
                  out_kind = KIND_INS_FAIL;
                end
              end
            end
            OP_DELETE: begin
              pop = 1'b1;
              for (int i = 0; i < SLOT_COUNT; i++) begin
                if (32'(head.item.sel) == i) begin
                  busy_next[i] = 1'b0;
                end
              end
            end
            default: begin
              pop       = 1'b1;
              busy_next = '0;
            end
          endcase
        end
      end
      BK_SCAN: begin
        pending_next = due;
        state_next   = (|due) ? BK_EMIT : BK_IDLE;
      end
      BK_EMIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_kind     = KIND_EXPIRED;
          out_idx      = pick_idx;
          out_tag      = pick_tag;
          pending_next = pending & ~pick_hot;
          busy_next    = busy & ~pick_hot;
          out_last     = (pending_next == '0);
          if (out_last) begin
            state_next = BK_IDLE;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_next = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      tick_inc  <= TICK_INC_RESET;
      cur_time  <= '0;
      busy      <= '0;
      pending   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cur_time  <= cur_time_next;
      busy      <= busy_next;
      pending   <= pending_next;
      out_valid <= out_valid_next;
      if (cfg.valid) begin
        tick_inc <= cfg.data;
      end
    end
  end

  // Arm the claimed slot
  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (ins_we && (free_idx == SLOT_W'(i))) begin
        expiry[i]   <= ins_expiry;
        slot_tag[i] <= head.item.tag;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      r_kind     <= out_kind;
      r_idx_ext  <= {2'b00, out_idx};
      r_tag      <= out_tag;
      r_last     <= out_last;
      rsp.time_now <= cur_time;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.kind        = r_kind;
  assign rsp.slot_number = r_idx_ext[1:0];
  assign rsp.expired_tag = r_tag;
  assign rsp.last        = r_last;

endmodule

// File: sv/one_shot_timer_pool.sv
// Top level of the one-shot timer pool: request queue, executor and checks.
//
// Requests enter a two-entry queue and are carried out one at a time. Insert,
// delete and free all are handled in the executor's idle state; a tick runs
// a saturating counter add, then a parallel compare of all slots, then one
// expiry per due slot, each expiry being sent from the single result
// register as soon as it is free. The request side keeps accepting while the
// queue has room, so a stalled result side only blocks once two requests wait.
// The increment register may be written only while the block is idle.
module one_shot_timer_pool
  import otp_pkg::*;
#(
  parameter int SLOT_COUNT = 3
) (
  input  logic      clk,
  input  logic      rst,
  otp_req_if.sink   req,
  otp_rsp_if.source rsp,
  otp_cfg_if.sink   cfg
);

  q_head_t head;
  logic    pop;

  otp_front u_front (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .head (head),
    .pop  (pop)
  );

  otp_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .cfg  (cfg),
    .rsp  (rsp)
  );

  // Executor never drains an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop from empty request queue");

  // A full queue always presents a head request
  a_full_has_head: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> head.valid)
    else $error("queue full but head not valid");

  // Insert results are single and final
  a_insert_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.kind != KIND_EXPIRED) |-> rsp.last)
    else $error("insert result without last");

  // Failed insert carries zero slot and tag
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.kind == KIND_INS_FAIL) |->
      (rsp.slot_number == 2'd0 && rsp.expired_tag == 16'd0))
    else $error("failed insert with nonzero fields");

endmodule
